// File: rtl/emseg_pkg.sv
package emseg_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int CODE_BITS             = 21;
   localparam int FIELD_BITS            = 16;
   localparam int REQ_DATA_BITS         = 24;
   localparam int RSP_DATA_BITS         = 3 * FIELD_BITS;
   localparam int RSP_USER_BITS         = 3;

   localparam logic [CODE_BITS-1:0] CP_RI_FIRST  = 21'h1F1E6;
   localparam logic [CODE_BITS-1:0] CP_RI_LAST   = 21'h1F1FF;
   localparam logic [CODE_BITS-1:0] CP_MOD_FIRST = 21'h1F3FB;
   localparam logic [CODE_BITS-1:0] CP_MOD_LAST  = 21'h1F3FF;
   localparam logic [CODE_BITS-1:0] CP_VS_TEXT   = 21'h0FE0E;
   localparam logic [CODE_BITS-1:0] CP_VS_EMOJI  = 21'h0FE0F;
   localparam logic [CODE_BITS-1:0] CP_ZWJ       = 21'h0200D;
   localparam logic [CODE_BITS-1:0] CP_KEYCAP    = 21'h020E3;
   localparam logic [CODE_BITS-1:0] CP_DIGIT_0   = 21'h00030;
   localparam logic [CODE_BITS-1:0] CP_DIGIT_9   = 21'h00039;
   localparam logic [CODE_BITS-1:0] CP_HASH      = 21'h00023;
   localparam logic [CODE_BITS-1:0] CP_STAR      = 21'h0002A;

   typedef enum logic [3:0] {
      MODE_START,
      MODE_BASE,
      MODE_VS,
      MODE_MOD,
      MODE_ZWJ,
      MODE_RI,
      MODE_KEY,
      MODE_KEYVS
   } mode_type;

   typedef struct packed {
      logic ri;
      logic modifier;
      logic vs;
      logic vs_emoji;
      logic zwj;
      logic keycap;
      logic keybase;
   } char_class_type;

   typedef struct packed {
      logic     joins;
      mode_type next;
   } step_type;

   typedef struct packed {
      logic                  starts_unit;
      logic [FIELD_BITS-1:0] position;
      logic [FIELD_BITS-1:0] unit_start;
      logic [FIELD_BITS-1:0] unit_number;
      logic                  ignorable;
      logic                  end_of_sequence;
      logic                  overflow;
   } result_type;

   function automatic step_type base_rules(mode_type level, char_class_type cls, logic last);
      step_type s;
      s.joins = 1'b0;
      s.next  = MODE_START;
      if (level == MODE_BASE && cls.vs) begin
         s.joins = 1'b1;
         s.next  = MODE_VS;
      end else if ((level == MODE_BASE || level == MODE_VS) && cls.modifier) begin
         s.joins = 1'b1;
         s.next  = MODE_MOD;
      end else if (cls.zwj && !last) begin
         s.joins = 1'b1;
         s.next  = MODE_ZWJ;
      end
      return s;
   endfunction

endpackage

// File: rtl/emseg_classify.sv
module emseg_classify
   import emseg_pkg::*;
(
   input  logic [CODE_BITS-1:0] code_point,
   output char_class_type       cls
);

   always_comb begin
      cls.ri       = (code_point >= CP_RI_FIRST) && (code_point <= CP_RI_LAST);
      cls.modifier = (code_point >= CP_MOD_FIRST) && (code_point <= CP_MOD_LAST);
      cls.vs_emoji = (code_point == CP_VS_EMOJI);
      cls.vs       = (code_point == CP_VS_TEXT) || cls.vs_emoji;
      cls.zwj      = (code_point == CP_ZWJ);
      cls.keycap   = (code_point == CP_KEYCAP);
      cls.keybase  = ((code_point >= CP_DIGIT_0) && (code_point <= CP_DIGIT_9))
                     || (code_point == CP_HASH) || (code_point == CP_STAR);
   end

endmodule

// File: rtl/emseg_core.sv
module emseg_core
   import emseg_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  char_class_type cls,
   input  logic           last,
   output result_type     result
);

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] ustart_ff, ustart_in;
   logic [FIELD_BITS-1:0]    ucount_ff, ucount_in;
   logic                     ovf_ff, ovf_in;
   step_type                 s;
   mode_type                 next_mode;

   always_comb begin
      s.joins = 1'b0;
      s.next  = MODE_START;
      case (mode_ff)
         MODE_ZWJ: begin
            s.joins = 1'b1;
            s.next  = MODE_BASE;
         end
         MODE_RI: begin
            if (cls.ri) begin
               s.joins = 1'b1;
               s.next  = MODE_START;
            end else begin
               s = base_rules(MODE_BASE, cls, last);
            end
         end
         MODE_KEY: begin
            if (cls.vs_emoji) begin
               s.joins = 1'b1;
               s.next  = MODE_KEYVS;
            end else if (cls.keycap) begin
               s.joins = 1'b1;
               s.next  = MODE_START;
            end else begin
               s = base_rules(MODE_BASE, cls, last);
            end
         end
         MODE_KEYVS: begin
            if (cls.keycap) begin
               s.joins = 1'b1;
               s.next  = MODE_START;
            end else begin
               s = base_rules(MODE_VS, cls, last);
            end
         end
         MODE_BASE, MODE_VS, MODE_MOD: begin
            s = base_rules(mode_ff, cls, last);
         end
         default: begin
            s.joins = 1'b0;
            s.next  = MODE_START;
         end
      endcase

      next_mode = s.next;
      ustart_in = ustart_ff;
      ucount_in = ucount_ff;
      if (!s.joins) begin
         ustart_in = pos_ff;
         if (ucount_ff != '1) begin
            ucount_in = ucount_ff + FIELD_BITS'(1);
         end
         if (cls.ri) begin
            next_mode = MODE_RI;
         end else if (cls.keybase) begin
            next_mode = MODE_KEY;
         end else begin
            next_mode = MODE_BASE;
         end
      end

      result.starts_unit     = !s.joins;
      result.position        = FIELD_BITS'(pos_ff);
      result.unit_start      = FIELD_BITS'(ustart_in);
      result.unit_number     = ucount_in;
      result.ignorable       = cls.zwj || cls.vs;
      result.end_of_sequence = last;
      result.overflow        = ovf_ff;

      mode_in = next_mode;
      pos_in  = pos_ff;
      ovf_in  = ovf_ff;
      if (pos_ff == '1) begin
         ovf_in = 1'b1;
      end else begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end
      if (last) begin
         mode_in   = MODE_START;
         pos_in    = '0;
         ustart_in = '0;
         ucount_in = '0;
         ovf_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_START;
         pos_ff    <= '0;
         ustart_ff <= '0;
         ucount_ff <= '0;
         ovf_ff    <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         ustart_ff <= ustart_in;
         ucount_ff <= ucount_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

// File: rtl/emoji_sequence_segmenter.sv
// Emoji sequence segmenter: takes one code point per item (tlast on the final code point
// of a sequence) and returns one item per input telling whether that code point opens a
// new emoji unit, with its position, the start index and ordinal of its unit, and
// ignorable and overflow flags. An item passes an input register and a result register,
// and one item is accepted every cycle as long as results are taken; the scan mode and
// counters update once per item.
// Position and unit start are the low 16 bits of a POSITION_BITS-wide saturating counter.
module emoji_sequence_segmenter
   import emseg_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // code_point[20:0], zero fill
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // position, unit_start, unit_number
   output logic [RSP_USER_BITS-1:0] rsp_tuser,  // starts_unit, ignorable, overflow
   output logic                     rsp_tlast
);

   logic                 in_valid_ff;
   logic [CODE_BITS-1:0] cp_ff;
   logic                 last_ff;
   logic                 out_valid_ff;
   result_type           rsp_ff;
   result_type           result;
   char_class_type       cls;
   logic                 out_free;
   logic                 step;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   emseg_classify u_classify (
      .code_point (cp_ff),
      .cls        (cls)
   );

   emseg_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cls    (cls),
      .last   (last_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cp_ff   <= req_tdata[CODE_BITS-1:0];
         last_ff <= req_tlast;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rsp_ff.unit_number, rsp_ff.unit_start, rsp_ff.position};
   assign rsp_tuser  = {rsp_ff.overflow, rsp_ff.ignorable, rsp_ff.starts_unit};
   assign rsp_tlast  = rsp_ff.end_of_sequence;

endmodule

// File: rtl/emseg_checker.sv
module emseg_checker
   import emseg_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [RSP_USER_BITS-1:0] rsp_tuser,
   input logic                     rsp_tlast
);

   logic rsp_take;
   assign rsp_take = rsp_tvalid && rsp_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input item held back without a stalled result");

   a_start_here: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_tuser[0] |-> rsp_tdata[31:16] == rsp_tdata[15:0])
      else $error("unit start differs from position on opening item");

   a_start_before: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_tdata[31:16] <= rsp_tdata[15:0])
      else $error("unit start beyond position");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_tdata[47:32] != 16'h0000)
      else $error("unit number zero on a result item");

endmodule

bind emoji_sequence_segmenter emseg_checker u_emseg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: dv/tb_emoji_sequence_segmenter.sv
module tb_emoji_sequence_segmenter;
   timeunit 1ns;
   timeprecision 1ps;

   import emseg_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1030;
   localparam int BURST_ITEMS  = 40;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // code_point[20:0], zero fill
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;       // position, unit_start, unit_number
   logic [RSP_USER_BITS-1:0] rsp_tuser;       // starts_unit, ignorable, overflow
   logic                     rsp_tlast;

   emoji_sequence_segmenter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // segmenter state mirrored in the testbench
   mode_type              seg_mode = MODE_START;
   logic [FIELD_BITS-1:0] seg_pos = '0;
   logic [FIELD_BITS-1:0] seg_unit_start = '0;
   logic [FIELD_BITS-1:0] seg_units = '0;
   logic                  seg_saturated = 1'b0;

   result_type            pending_segments[$];
   logic [CODE_BITS-1:0]  seq_points[$];
   bit                    idling = 1'b1;
   int                    mismatches = 0;
   int                    items_sent = 0;
   int                    sequences_sent = 0;
   int                    results_checked = 0;
   int                    cycle_count = 0;
   int                    rsp_stall_left = 0;
   result_type            want;

   function automatic bit is_regional(logic [CODE_BITS-1:0] c);
      return c >= CP_RI_FIRST && c <= CP_RI_LAST;
   endfunction

   function automatic bit is_skin_tone(logic [CODE_BITS-1:0] c);
      return c >= CP_MOD_FIRST && c <= CP_MOD_LAST;
   endfunction

   function automatic bit is_selector(logic [CODE_BITS-1:0] c);
      return c == CP_VS_TEXT || c == CP_VS_EMOJI;
   endfunction

   function automatic bit is_keycap_base(logic [CODE_BITS-1:0] c);
      return (c >= CP_DIGIT_0 && c <= CP_DIGIT_9) || c == CP_HASH || c == CP_STAR;
   endfunction

   function automatic bit extends_base(mode_type level, logic [CODE_BITS-1:0] c,
                                       logic last_flag, output mode_type nxt);
      nxt = MODE_START;
      if (level == MODE_BASE && is_selector(c)) begin
         nxt = MODE_VS;
         return 1'b1;
      end
      if ((level == MODE_BASE || level == MODE_VS) && is_skin_tone(c)) begin
         nxt = MODE_MOD;
         return 1'b1;
      end
      if (c == CP_ZWJ && !last_flag) begin
         nxt = MODE_ZWJ;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic result_type segment_code_point(logic [CODE_BITS-1:0] c, logic last_flag);
      result_type r;
      mode_type   nxt;
      bit         joins;
      nxt = MODE_START;
      joins = 1'b0;
      case (seg_mode)
         MODE_ZWJ: begin
            joins = 1'b1;
            nxt = MODE_BASE;
         end
         MODE_RI: begin
            if (is_regional(c)) begin
               joins = 1'b1;
               nxt = MODE_START;
            end else begin
               joins = extends_base(MODE_BASE, c, last_flag, nxt);
            end
         end
         MODE_KEY: begin
            if (c == CP_VS_EMOJI) begin
               joins = 1'b1;
               nxt = MODE_KEYVS;
            end else if (c == CP_KEYCAP) begin
               joins = 1'b1;
               nxt = MODE_START;
            end else begin
               joins = extends_base(MODE_BASE, c, last_flag, nxt);
            end
         end
         MODE_KEYVS: begin
            if (c == CP_KEYCAP) begin
               joins = 1'b1;
               nxt = MODE_START;
            end else begin
               joins = extends_base(MODE_VS, c, last_flag, nxt);
            end
         end
         MODE_BASE, MODE_VS, MODE_MOD: begin
            joins = extends_base(seg_mode, c, last_flag, nxt);
         end
         default: begin
            joins = 1'b0;
         end
      endcase
      if (!joins) begin
         seg_unit_start = seg_pos;
         if (seg_units != FIELD_MAX) seg_units++;
         if (is_regional(c)) nxt = MODE_RI;
         else if (is_keycap_base(c)) nxt = MODE_KEY;
         else nxt = MODE_BASE;
      end
      r.starts_unit     = !joins;
      r.position        = seg_pos;
      r.unit_start      = seg_unit_start;
      r.unit_number     = seg_units;
      r.ignorable       = c == CP_ZWJ || is_selector(c);
      r.end_of_sequence = last_flag;
      r.overflow        = seg_saturated;
      if (last_flag) begin
         seg_mode = MODE_START;
         seg_pos = '0;
         seg_unit_start = '0;
         seg_units = '0;
         seg_saturated = 1'b0;
      end else begin
         seg_mode = nxt;
         if (seg_pos == FIELD_MAX) seg_saturated = 1'b1;
         else seg_pos++;
      end
      return r;
   endfunction

   function void check_field(string name, logic [FIELD_BITS-1:0] exp_val,
                             logic [FIELD_BITS-1:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         mismatches++;
      end
   endfunction

   function void check_flag(string name, logic exp_val, logic got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         mismatches++;
      end
   endfunction

   task automatic add_point(logic [CODE_BITS-1:0] c);
      seq_points.insert(seq_points.size(), c);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_emoji_sequence_segmenter failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || !idling) begin
         rsp_tready <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_segments.size() == 0) begin
            $error("result item with no pending prediction");
            mismatches++;
         end else begin
            want = pending_segments.pop_front();
            results_checked++;
            check_flag("starts_unit", want.starts_unit, rsp_tuser[0]);
            check_field("position", want.position, rsp_tdata[15:0]);
            check_field("unit_start", want.unit_start, rsp_tdata[31:16]);
            check_field("unit_number", want.unit_number, rsp_tdata[47:32]);
            check_flag("ignorable", want.ignorable, rsp_tuser[1]);
            check_flag("end_of_sequence", want.end_of_sequence, rsp_tlast);
            check_flag("overflow", want.overflow, rsp_tuser[2]);
         end
      end
   end

   task automatic send_code_point(logic [CODE_BITS-1:0] c, logic last_flag);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_BITS - CODE_BITS){1'b0}}, c};
      req_tlast <= last_flag;
      pending_segments.insert(pending_segments.size(), segment_code_point(c, last_flag));
      items_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_sequence();
      int n;
      n = seq_points.size();
      for (int i = 0; i < n; i++) send_code_point(seq_points[i], i == n - 1);
      seq_points.delete();
      sequences_sent++;
   endtask

   function automatic logic [CODE_BITS-1:0] pick_base();
      case ($urandom_range(0, 2))
         0: return CODE_BITS'($urandom_range(21'h00040, 21'h01FFF));
         1: return CODE_BITS'($urandom_range(21'h1F300, 21'h1F3FA));
         default: return CODE_BITS'($urandom_range(21'h1F400, 21'h1FAFF));
      endcase
   endfunction

   function automatic logic [CODE_BITS-1:0] pick_keycap_base();
      int k;
      k = $urandom_range(0, 11);
      if (k == 10) return CP_HASH;
      if (k == 11) return CP_STAR;
      return CP_DIGIT_0 + CODE_BITS'(k);
   endfunction

   function automatic logic [CODE_BITS-1:0] pick_regional();
      return CODE_BITS'($urandom_range(CP_RI_FIRST, CP_RI_LAST));
   endfunction

   function automatic logic [CODE_BITS-1:0] pick_skin_tone();
      return CODE_BITS'($urandom_range(CP_MOD_FIRST, CP_MOD_LAST));
   endfunction

   task automatic append_unit();
      case ($urandom_range(0, 11))
         0: add_point(pick_base());
         1: begin
            add_point(pick_base());
            add_point($urandom_range(0, 1) ? CP_VS_EMOJI : CP_VS_TEXT);
         end
         2: begin
            add_point(pick_base());
            add_point(pick_skin_tone());
         end
         3: begin
            add_point(pick_base());
            add_point(CP_VS_EMOJI);
            add_point(pick_skin_tone());
         end
         4: begin
            add_point(pick_base());
            if ($urandom_range(0, 1)) add_point(pick_skin_tone());
            repeat ($urandom_range(1, 3)) begin
               add_point(CP_ZWJ);
               add_point(pick_base());
               if ($urandom_range(0, 2) == 0) add_point(CP_VS_EMOJI);
            end
         end
         5: begin
            add_point(pick_regional());
            add_point(pick_regional());
         end
         6: begin
            add_point(pick_keycap_base());
            if ($urandom_range(0, 1)) add_point(CP_VS_EMOJI);
            add_point(CP_KEYCAP);
         end
         7: add_point(pick_regional());
         8: begin
            add_point(pick_keycap_base());
            if ($urandom_range(0, 1)) add_point(CP_VS_EMOJI);
         end
         9: begin
            case ($urandom_range(0, 4))
               0: add_point(CP_ZWJ);
               1: add_point(CP_VS_TEXT);
               2: add_point(CP_VS_EMOJI);
               3: add_point(CP_KEYCAP);
               default: add_point(pick_skin_tone());
            endcase
         end
         default: add_point(CODE_BITS'($urandom_range(0, 21'h1FFFFF)));
      endcase
   endtask

   task automatic test_special_cases();
      // combined unit, selector after a joined code point, regional pairs, keycaps, final ZWJ
      seq_points = '{21'h00000, CP_VS_EMOJI, CP_MOD_FIRST, CP_ZWJ, CP_RI_FIRST, CP_VS_TEXT,
                     CP_RI_FIRST, CP_RI_LAST, CP_RI_LAST, 21'h00041,
                     CP_HASH, CP_VS_EMOJI, CP_KEYCAP, CP_STAR, CP_KEYCAP,
                     CP_DIGIT_9, CP_MOD_LAST, CP_DIGIT_0, CP_VS_EMOJI, CP_MOD_FIRST,
                     21'h1FFFFF, 21'h10FFFF, CP_ZWJ};
      send_sequence();
      // a ZWJ joined through another ZWJ at the end of the sequence
      seq_points = '{21'h1F600, CP_ZWJ, CP_ZWJ};
      send_sequence();
   endtask

   task automatic test_random_sequences();
      int start_count;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         repeat ($urandom_range(1, 8)) append_unit();
         send_sequence();
      end
   endtask

   task automatic test_back_to_back();
      for (int i = 0; i < BURST_ITEMS; i++) begin
         add_point($urandom_range(0, 1) ? CODE_BITS'($urandom_range(21'h00040, 21'h01FFF))
                                        : CODE_BITS'($urandom_range(21'h02100, 21'h0FDFF)));
      end
      send_sequence();
      // counters must restart on the next sequence
      seq_points = '{CP_HASH, CP_KEYCAP, 21'h00041};
      send_sequence();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_random_sequences();
      idling = 1'b0;
      test_back_to_back();
      req_tvalid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d code points in %0d sequences; %0d results checked.",
               items_sent, sequences_sent, results_checked);
      $display("Covered keycaps, flags, ZWJ chains, modifiers, noise and gapless traffic.");
      if (mismatches == 0) begin
         $display("tb_emoji_sequence_segmenter passed");
      end else begin
         $display("tb_emoji_sequence_segmenter failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/emseg_pkg.sv
rtl/emseg_classify.sv
rtl/emseg_core.sv
rtl/emoji_sequence_segmenter.sv
rtl/emseg_checker.sv
dv/tb_emoji_sequence_segmenter.sv
